[hdl/gmds_pkg.sv]
`timescale 1ns / 1ps

package gmds_pkg;

    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LOAD    = 2'd0;
    localparam t_cmd CMD_SOLVE   = 2'd1;
    localparam t_cmd CMD_READ    = 2'd2;
    localparam t_cmd CMD_UNKNOWN = 2'd3;

    localparam t_status ST_FREE = 2'd0;
    localparam t_status ST_WALL = 2'd1;
    localparam t_status ST_SEEN = 2'd2;
    localparam t_status ST_PATH = 2'd3;

    localparam int CFG_GOAL_ROW = 0;
    localparam int CFG_GOAL_COL = 1;

    localparam int PATH_LEN_MAX = 2047;

endpackage

[hdl/grid_maze_dfs_solver.sv]
`timescale 1ns / 1ps

// Depth-first maze solver for a GRID_DIM x GRID_DIM grid held in an on-chip cell memory.
// Every command returns one result transaction. A load answers straight from idle; a read
// waits for the registered read of the cell memory. A solve first sweeps the whole cell
// memory to clear old marks, then runs the search as a sequencer around one memory read
// per neighbour probe, backtracks through the cell stack, and on success marks each path
// cell read back from the stack. The block takes no new command while a solve runs.
// After reset the block clears every cell to free and takes no command meanwhile.
module grid_maze_dfs_solver
    import gmds_pkg::*;
#(
    parameter int GRID_DIM = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [4:0]  i_row,
    input  logic [4:0]  i_col,
    input  logic        i_wall,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [10:0] o_path_len,
    output logic [1:0]  o_cell_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int CW    = $clog2(GRID_DIM);
    localparam int IW    = $clog2(CELLS);
    localparam int SPW   = $clog2(CELLS + 1);
    localparam logic [CW:0] GD = (CW + 1)'(GRID_DIM);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_PROBE = 4'd4;
    localparam logic [3:0] S_PWAIT = 4'd5;
    localparam logic [3:0] S_POPW  = 4'd6;
    localparam logic [3:0] S_MRD   = 4'd7;
    localparam logic [3:0] S_MWR   = 4'd8;
    localparam logic [3:0] S_INIT  = 4'd9;

    t_status          r_map [CELLS];
    logic [2*CW-1:0]  r_stk [CELLS];

    logic [3:0]       r_state, n_state;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [SPW-1:0]   r_idx, n_idx;
    logic [IW-1:0]    r_prev, n_prev;
    logic             r_pv, n_pv;
    logic [2:0]       r_dir, n_dir;
    logic [CW-1:0]    r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [CW-1:0]    r_nb_row, n_nb_row, r_nb_col, n_nb_col;
    logic [CW-1:0]    r_st_row, n_st_row, r_st_col, n_st_col;
    logic             r_rd_in, n_rd_in;
    logic             r_last_found, n_last_found;
    logic [4:0]       r_goal_row, r_goal_col;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;
    logic [10:0]      r_path_len, n_path_len;
    t_status          r_status, n_status;
    t_status          r_map_q;
    logic [2*CW-1:0]  r_stk_q;

    logic             w_map_we;
    logic [IW-1:0]    w_map_waddr, w_map_raddr;
    t_status          w_map_wdata;
    logic             w_stk_we;
    logic [IW-1:0]    w_stk_waddr, w_stk_raddr;
    logic [2*CW-1:0]  w_stk_wdata;

    logic             w_in_acc;
    logic             w_inside;
    logic             w_goal_in;
    logic             w_nb_ok;
    logic [CW-1:0]    w_nb_row, w_nb_col;
    logic [CW-1:0]    w_par_row, w_par_col;
    logic [2:0]       w_back_dir;
    logic [SPW-1:0]   w_sp_dec;

    function automatic logic [IW-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return IW'(int'(r) * GRID_DIM + int'(c));
    endfunction

    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;
    assign w_inside    = (int'(i_row) < GRID_DIM) && (int'(i_col) < GRID_DIM);
    assign w_goal_in   = (int'(r_goal_row) < GRID_DIM) && (int'(r_goal_col) < GRID_DIM);
    assign w_sp_dec    = r_sp - SPW'(1);
    assign w_par_row   = r_stk_q[2*CW-1:CW];
    assign w_par_col   = r_stk_q[CW-1:0];

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_path_len    = r_path_len;
    assign o_cell_status = r_status;

    always_comb begin
        w_nb_ok  = 1'b0;
        w_nb_row = r_cur_row;
        w_nb_col = r_cur_col;
        case (r_dir)
            3'd0: begin
                w_nb_ok  = (r_cur_row != '0);
                w_nb_row = r_cur_row - CW'(1);
            end
            3'd1: begin
                w_nb_ok  = ((CW + 1)'(r_cur_row) + (CW + 1)'(1)) < GD;
                w_nb_row = r_cur_row + CW'(1);
            end
            3'd2: begin
                w_nb_ok  = (r_cur_col != '0);
                w_nb_col = r_cur_col - CW'(1);
            end
            3'd3: begin
                w_nb_ok  = ((CW + 1)'(r_cur_col) + (CW + 1)'(1)) < GD;
                w_nb_col = r_cur_col + CW'(1);
            end
            default: w_nb_ok = 1'b0;
        endcase
    end

    always_comb begin
        if ((CW + 1)'(w_par_row) == (CW + 1)'(r_cur_row) + (CW + 1)'(1)) begin
            w_back_dir = 3'd1;
        end else if ((CW + 1)'(w_par_row) + (CW + 1)'(1) == (CW + 1)'(r_cur_row)) begin
            w_back_dir = 3'd2;
        end else if ((CW + 1)'(w_par_col) == (CW + 1)'(r_cur_col) + (CW + 1)'(1)) begin
            w_back_dir = 3'd3;
        end else begin
            w_back_dir = 3'd4;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_idx        = r_idx;
        n_prev       = r_prev;
        n_pv         = r_pv;
        n_dir        = r_dir;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_nb_row     = r_nb_row;
        n_nb_col     = r_nb_col;
        n_st_row     = r_st_row;
        n_st_col     = r_st_col;
        n_rd_in      = r_rd_in;
        n_last_found = r_last_found;
        n_out_valid  = r_out_valid && !i_ready;
        n_found      = r_found;
        n_path_len   = r_path_len;
        n_status     = r_status;
        w_map_we     = 1'b0;
        w_map_waddr  = f_addr(r_cur_row, r_cur_col);
        w_map_wdata  = ST_SEEN;
        w_map_raddr  = f_addr(r_cur_row, r_cur_col);
        w_stk_we     = 1'b0;
        w_stk_waddr  = IW'(r_sp);
        w_stk_wdata  = {r_cur_row, r_cur_col};
        w_stk_raddr  = IW'(w_sp_dec - SPW'(1));

        unique case (r_state)
            S_INIT: begin
                w_map_we    = 1'b1;
                w_map_waddr = IW'(r_idx);
                w_map_wdata = ST_FREE;
                if (int'(r_idx) == CELLS - 1) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + SPW'(1);
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_st_row = CW'(i_row);
                    n_st_col = CW'(i_col);
                    n_rd_in  = w_inside;
                    unique case (i_cmd)
                        CMD_LOAD: begin
                            w_map_we    = w_inside;
                            w_map_waddr = f_addr(CW'(i_row), CW'(i_col));
                            w_map_wdata = i_wall ? ST_WALL : ST_FREE;
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_path_len  = '0;
                            n_status    = ST_FREE;
                        end
                        CMD_SOLVE: begin
                            n_idx   = '0;
                            n_pv    = 1'b0;
                            n_state = S_CLR;
                        end
                        CMD_READ: begin
                            w_map_raddr = f_addr(CW'(i_row), CW'(i_col));
                            n_state     = S_RD;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_path_len  = '0;
                            n_status    = ST_FREE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_found     = 1'b0;
                n_path_len  = '0;
                n_status    = r_rd_in ? r_map_q : ST_WALL;
                n_state     = S_IDLE;
            end
            S_CLR: begin
                w_map_raddr = IW'(r_idx);
                w_map_we    = r_pv && r_map_q[1];
                w_map_waddr = r_prev;
                w_map_wdata = ST_FREE;
                n_prev      = IW'(r_idx);
                n_pv        = (int'(r_idx) < CELLS);
                if (int'(r_idx) < CELLS) begin
                    n_idx = r_idx + SPW'(1);
                end else if (!r_pv) begin
                    n_sp      = '0;
                    n_cur_row = r_st_row;
                    n_cur_col = r_st_col;
                    n_dir     = '0;
                    if (!r_rd_in) begin
                        n_last_found = 1'b0;
                        n_out_valid  = 1'b1;
                        n_found      = 1'b0;
                        n_path_len   = '0;
                        n_status     = ST_FREE;
                        n_state      = S_IDLE;
                    end else begin
                        w_map_raddr = f_addr(r_st_row, r_st_col);
                        n_state     = S_SCHK;
                    end
                end
            end
            S_SCHK: begin
                if (r_map_q == ST_WALL) begin
                    n_last_found = 1'b0;
                    n_out_valid  = 1'b1;
                    n_found      = 1'b0;
                    n_path_len   = '0;
                    n_status     = ST_FREE;
                    n_state      = S_IDLE;
                end else begin
                    w_map_we    = 1'b1;
                    w_stk_we    = 1'b1;
                    w_stk_waddr = '0;
                    n_sp        = SPW'(1);
                    if (w_goal_in && r_cur_row == CW'(r_goal_row)
                            && r_cur_col == CW'(r_goal_col)) begin
                        n_idx   = '0;
                        n_state = S_MRD;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_dir == 3'd4) begin
                    n_sp = w_sp_dec;
                    if (w_sp_dec == '0) begin
                        n_last_found = 1'b0;
                        n_out_valid  = 1'b1;
                        n_found      = 1'b0;
                        n_path_len   = '0;
                        n_status     = ST_FREE;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_POPW;
                    end
                end else if (!w_nb_ok || int'(r_sp) >= CELLS) begin
                    n_dir = r_dir + 3'd1;
                end else begin
                    w_map_raddr = f_addr(w_nb_row, w_nb_col);
                    n_nb_row    = w_nb_row;
                    n_nb_col    = w_nb_col;
                    n_state     = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (r_map_q == ST_FREE) begin
                    w_map_we    = 1'b1;
                    w_map_waddr = f_addr(r_nb_row, r_nb_col);
                    w_stk_we    = 1'b1;
                    w_stk_wdata = {r_nb_row, r_nb_col};
                    n_sp        = r_sp + SPW'(1);
                    n_cur_row   = r_nb_row;
                    n_cur_col   = r_nb_col;
                    n_dir       = '0;
                    if (w_goal_in && r_nb_row == CW'(r_goal_row)
                            && r_nb_col == CW'(r_goal_col)) begin
                        n_idx   = '0;
                        n_state = S_MRD;
                    end else begin
                        n_state = S_PROBE;
                    end
                end else begin
                    n_dir   = r_dir + 3'd1;
                    n_state = S_PROBE;
                end
            end
            S_POPW: begin
                n_dir     = w_back_dir;
                n_cur_row = w_par_row;
                n_cur_col = w_par_col;
                n_state   = S_PROBE;
            end
            S_MRD: begin
                if (r_idx == r_sp) begin
                    n_last_found = 1'b1;
                    n_out_valid  = 1'b1;
                    n_found      = 1'b1;
                    n_path_len   = (32'(r_sp) > 32'(PATH_LEN_MAX))
                                 ? 11'(PATH_LEN_MAX) : 11'(r_sp);
                    n_status     = ST_FREE;
                    n_state      = S_IDLE;
                end else begin
                    w_stk_raddr = IW'(r_idx);
                    n_state     = S_MWR;
                end
            end
            S_MWR: begin
                w_map_we    = 1'b1;
                w_map_waddr = f_addr(w_par_row, w_par_col);
                w_map_wdata = ST_PATH;
                n_idx       = r_idx + SPW'(1);
                n_state     = S_MRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[w_map_waddr] <= w_map_wdata;
        end
        r_map_q <= r_map[w_map_raddr];
        if (w_stk_we) begin
            r_stk[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_q <= r_stk[w_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sp         <= '0;
            r_idx        <= '0;
            r_pv         <= 1'b0;
            r_dir        <= '0;
            r_last_found <= 1'b0;
            r_out_valid  <= 1'b0;
            r_goal_row   <= 5'd0;
            r_goal_col   <= 5'd1;
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_idx        <= n_idx;
            r_pv         <= n_pv;
            r_dir        <= n_dir;
            r_last_found <= n_last_found;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == 1'(CFG_GOAL_ROW)) begin
                    r_goal_row <= i_cfg_data;
                end else begin
                    r_goal_col <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_nb_row   <= n_nb_row;
        r_nb_col   <= n_nb_col;
        r_st_row   <= n_st_row;
        r_st_col   <= n_st_col;
        r_rd_in    <= n_rd_in;
        r_found    <= n_found;
        r_path_len <= n_path_len;
        r_status   <= n_status;
    end

endmodule
